// File: rtl/dedup_record_sorter_core_macros.svh
// assertion helpers for the record sorter checker
`ifndef DEDUP_RECORD_SORTER_CORE_MACROS_SVH
`define DEDUP_RECORD_SORTER_CORE_MACROS_SVH

// plain clocked check, reset masks it
`define DRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication built on the plain check
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DRS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/drs_pkg.sv
`timescale 1ns / 1ps
package drs_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W       = $clog2(MAX_RECORDS);

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_SORT   = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] key;
    logic [63:0]        name_head;
    logic [7:0]         name_tail;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic [63:0]        out_name_head;
    logic [7:0]         out_name_tail;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_head;
    logic [7:0]         name_tail;
  } record_t;

  // shared controls broadcast along the chain
  typedef struct packed {
    logic ins_en;
    logic rot_en;
  } chain_ctrl_t;

endpackage

// File: rtl/drs_cell.sv
`timescale 1ns / 1ps
module drs_cell
  import drs_pkg::*;
(
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        occ_i,
  input  logic        tail_i,
  input  record_t     new_rec_i,
  input  record_t     left_rec_i,
  input  logic        left_cond_i,
  input  record_t     right_rec_i,
  input  record_t     head_rec_i,
  output record_t     rec_o,
  output logic        cond_o,
  output logic        eq_o
);

  record_t rec_q, rec_d;
  logic    gt;

  // empty slot or stored key above the new one
  assign gt     = occ_i && ($signed(rec_q.key) > $signed(new_rec_i.key));
  assign cond_o = !occ_i || gt;
  assign eq_o   = occ_i && (rec_q.key == new_rec_i.key);
  assign rec_o  = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.ins_en) begin
      if (left_cond_i) begin
        rec_d = left_rec_i;
      end else if (cond_o) begin
        rec_d = new_rec_i;
      end
    end else if (ctrl_i.rot_en && occ_i) begin
      rec_d = tail_i ? head_rec_i : right_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// File: rtl/drs_chain.sv
`timescale 1ns / 1ps
module drs_chain
  import drs_pkg::*;
(
  input  logic             clk_i,
  input  chain_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  record_t          new_rec_i,
  output record_t          head_rec_o,
  output logic             dup_o
);

  record_t                recs [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] cond;
  logic [MAX_RECORDS-1:0] eq;

  assign head_rec_o = recs[0];
  assign dup_o      = |eq;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic    occ, tail, lcond;
    record_t lrec, rrec;

    assign occ  = CNT_W'(i) < count_i;
    assign tail = CNT_W'(i + 1) == count_i;

    if (i == 0) begin : g_first
      assign lcond = 1'b0;
      assign lrec  = new_rec_i;
    end else begin : g_mid
      assign lcond = cond[i-1];
      assign lrec  = recs[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_last
      assign rrec = recs[0];
    end else begin : g_inner
      assign rrec = recs[i+1];
    end

    drs_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .occ_i       (occ),
      .tail_i      (tail),
      .new_rec_i   (new_rec_i),
      .left_rec_i  (lrec),
      .left_cond_i (lcond),
      .right_rec_i (rrec),
      .head_rec_i  (recs[0]),
      .rec_o       (recs[i]),
      .cond_o      (cond[i]),
      .eq_o        (eq[i])
    );
  end

endmodule

// File: rtl/dedup_record_sorter_core.sv
`timescale 1ns / 1ps
// channel | valid      | ready      | payload
// input   | in_valid_i | in_ready_o | in_item_i  (cmd, key, name_head, name_tail)
// output  | out_valid_o| out_ready_i| out_item_o (out_key, out_name_head, out_name_tail, last)
//
// an insert leaves the input ready; a new item may follow in the next cycle
// a sort with n stored records holds the input until all n have been emitted,
//   one record leaves cell 0 per cycle unless stalled, while the chain rotates back into order
// reset clears the record count and the emit state; cell contents are not cleared
// an output stall freezes the rotation; the output register holds the pending record
module dedup_record_sorter_core
  import drs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] emit_cnt_q;
  logic             out_valid_q;
  out_item_t        out_q;

  chain_ctrl_t ctrl;
  record_t     new_rec, head_rec;
  logic        dup, in_xfer, is_sort, advance, is_last, full;
  logic        ins_en, rot_en;

  assign in_xfer = in_valid_i && in_ready_o;
  assign is_sort = in_item_i.cmd == CMD_SORT;
  assign full    = count_q == CNT_W'(MAX_RECORDS);

  // output slot free or being drained this cycle
  assign advance = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign is_last = {1'b0, emit_cnt_q} == (count_q - CNT_W'(1));

  assign new_rec.key       = in_item_i.key;
  assign new_rec.name_head = in_item_i.name_head;
  assign new_rec.name_tail = in_item_i.name_tail;

  // insert only a fresh key into a store with room
  assign ins_en = in_xfer && !is_sort && !dup && !full;
  assign ctrl   = '{ins_en: ins_en, rot_en: rot_en};

  drs_chain u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .count_i    (count_q),
    .new_rec_i  (new_rec),
    .head_rec_o (head_rec),
    .dup_o      (dup)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_sort && (count_q != '0)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    rot_en     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EMIT: rot_en     = advance;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ins_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      // index of the record now at the head of the chain
      if (advance) begin
        emit_cnt_q <= is_last ? '0 : emit_cnt_q + IDX_W'(1);
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload register, loaded from cell 0
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_key       <= head_rec.key;
      out_q.out_name_head <= head_rec.name_head;
      out_q.out_name_tail <= head_rec.name_tail;
      out_q.last          <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/drs_checker.sv
`timescale 1ns / 1ps
`include "dedup_record_sorter_core_macros.svh"
module drs_checker
  import drs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // while a sort is running the output is filled from the next cycle on
  `DRS_ASSERT_NEXT(a_emit_fills_out, !in_ready_o, out_valid_o, "emit left output empty")

  // an insert never starts an emission
  `DRS_ASSERT_NEXT(a_insert_stays_ready, in_valid_i && in_ready_o && in_item_i.cmd == CMD_INSERT, in_ready_o, "insert blocked input")

  // input closes only after a sort transfer
  `DRS_ASSERT(a_busy_after_sort, $fell(in_ready_o) |-> $past(in_valid_i && in_item_i.cmd == CMD_SORT), "input closed without sort")

  // stalled result holds
  `DRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "stalled output changed")

endmodule

bind dedup_record_sorter_core drs_checker u_drs_checker (.*);

// File: bench/tb_dedup_record_sorter_core.sv
`timescale 1ns / 1ps
module tb_dedup_record_sorter_core;
  import drs_pkg::*;

  localparam int RANDOM_ITEMS     = 240;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 2 * MAX_RECORDS + 16;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_REPORTS      = 200;

  // one row of the directed walk; exp_n < 0 means the store model decides
  typedef struct {
    cmd_e        cmd;
    logic [31:0] key;
    logic [63:0] head;
    logic [7:0]  tail;
    int          exp_n;
    logic [31:0] exp_key;
    logic [63:0] exp_head;
    logic [7:0]  exp_tail;
  } directed_row_t;

  localparam int N_DIRECTED = 19;

  directed_row_t directed_rows [N_DIRECTED] = '{
    // sort on an empty store returns nothing, its key and name are ignored
    '{CMD_SORT,   32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 0, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_SORT,   32'h0000_0000, 64'h0, 8'h00,
      1, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF},
    // duplicate of the most negative key, the first name must survive
    '{CMD_INSERT, 32'h8000_0000, 64'h0, 8'h00, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_SORT,   32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 8'h00,
      1, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF},
    '{CMD_INSERT, 32'h7FFF_FFFF, 64'h0, 8'h00, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h0000_0000, 64'h0123_4567_89AB_CDEF, 8'h5A, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'hFFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h0000_0001, 64'h5555_5555_5555_5555, 8'h55, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_SORT,   32'h8000_0000, 64'hFFFF_0000_FFFF_0000, 8'h0F, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h7FFF_FFFF, 64'hFEDC_BA98_7654_3210, 8'h11, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'hFFFF_FFFF, 64'h1111_2222_3333_4444, 8'h22, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h8000_0001, 64'h0000_0000_0000_0001, 8'h80, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h7FFF_FFFE, 64'h8000_0000_0000_0000, 8'h01, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_SORT,   32'h0000_0000, 64'h0, 8'h00, -1, 32'h0, 64'h0, 8'h00},
    // back to back sorts, the store keeps its records
    '{CMD_SORT,   32'h5A5A_A5A5, 64'hDEAD_BEEF_CAFE_F00D, 8'hC3, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_INSERT, 32'hFFFF_FFFE, 64'h0F0F_0F0F_0F0F_0F0F, 8'hF0, -1, 32'h0, 64'h0, 8'h00},
    '{CMD_SORT,   32'hFFFF_FFFF, 64'h0, 8'hFF, -1, 32'h0, 64'h0, 8'h00}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  dedup_record_sorter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // model of the keyed store, kept in ascending signed key order
  record_t     sorted_store [MAX_RECORDS];
  int          stored_count = 0;
  out_item_t   pending_records [$];

  // per offered item: typed result count (or -1) and the typed record
  int          planned_count_q [$];
  record_t     planned_record_q [$];

  logic [31:0] key_pool [$];
  logic [31:0] boundary_keys [6] = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
                                     32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF};

  int   err_count       = 0;
  int   inserts_seen    = 0;
  int   sorts_seen      = 0;
  int   records_checked = 0;
  int   dup_drops       = 0;
  int   full_drops      = 0;
  int   cycle_count     = 0;
  int   burst_left      = 0;
  logic random_started  = 1'b0;
  logic long_hold_done  = 1'b0;

  function automatic void store_insert(logic [31:0] key, logic [63:0] head, logic [7:0] tail);
    int pos;
    pos = 0;
    while (pos < stored_count && $signed(sorted_store[pos].key) < $signed(key)) pos++;
    if (pos < stored_count && sorted_store[pos].key == key) begin
      dup_drops++;
      return;
    end
    if (stored_count >= MAX_RECORDS) begin
      full_drops++;
      return;
    end
    for (int i = stored_count; i > pos; i--) sorted_store[i] = sorted_store[i - 1];
    sorted_store[pos].key       = key;
    sorted_store[pos].name_head = head;
    sorted_store[pos].name_tail = tail;
    stored_count++;
  endfunction

  function automatic void emit_sorted_store();
    out_item_t rec;
    for (int i = 0; i < stored_count; i++) begin
      rec.out_key       = sorted_store[i].key;
      rec.out_name_head = sorted_store[i].name_head;
      rec.out_name_tail = sorted_store[i].name_tail;
      rec.last          = (i == stored_count - 1);
      pending_records.push_back(rec);
    end
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  function automatic void check_record(out_item_t got);
    out_item_t want;
    if (pending_records.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: unexpected record, expected none, actual key %h name %h_%h last %b",
                 $time, got.out_key, got.out_name_tail, got.out_name_head, got.last);
      return;
    end
    want = pending_records.pop_front();
    check_field("out_key", 64'(want.out_key), 64'(got.out_key));
    check_field("out_name_head", want.out_name_head, got.out_name_head);
    check_field("out_name_tail", 64'(want.out_name_tail), 64'(got.out_name_tail));
    check_field("last", 64'(want.last), 64'(got.last));
    records_checked++;
  endfunction

  // transfers seen at the clock edge: input first, so a sort's records queue up in order
  always @(posedge clk_i) begin : transfer_monitor
    int      plan_n;
    record_t plan_rec;
    out_item_t typed;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        plan_n   = -1;
        plan_rec = '0;
        if (planned_count_q.size() > 0) begin
          plan_n   = planned_count_q.pop_front();
          plan_rec = planned_record_q.pop_front();
        end
        if (in_item_i.cmd == CMD_SORT) begin
          sorts_seen++;
          if (plan_n < 0) begin
            emit_sorted_store();
          end else if (plan_n == 1) begin
            typed.out_key       = plan_rec.key;
            typed.out_name_head = plan_rec.name_head;
            typed.out_name_tail = plan_rec.name_tail;
            typed.last          = 1'b1;
            pending_records.push_back(typed);
          end
        end else begin
          inserts_seen++;
          store_insert(in_item_i.key, in_item_i.name_head, in_item_i.name_tail);
        end
      end
      if (out_valid_o && out_ready_i) check_record(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records still expected",
               cycle_count, pending_records.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall modes of random length, plus one long hold-off mid-sort
  initial begin : sink_pattern
    int mode;
    int mode_left;
    logic toggle;
    mode      = 0;
    mode_left = 0;
    toggle    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && random_started && !long_hold_done && out_valid_o) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      toggle = ~toggle;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= toggle;
      endcase
    end
  end

  // idle between bursts; payload is junk while valid is low
  task automatic sender_gap();
    logic [127:0] junk;
    int gap;
    if (burst_left > 0) return;
    burst_left = $urandom_range(1, 12);
    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
    if (gap == 0) return;
    junk = {$urandom, $urandom, $urandom, $urandom};
    in_valid_i <= 1'b0;
    in_item_i  <= junk[$bits(in_item_t)-1:0];
    repeat (gap) @(posedge clk_i);
  endtask

  // hold the item until the transfer happens
  task automatic offer_item(in_item_t item, int exp_n, record_t exp_rec);
    sender_gap();
    burst_left--;
    planned_count_q.push_back(exp_n);
    planned_record_q.push_back(exp_rec);
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic in_item_t random_item();
    in_item_t item;
    int pick;
    item.cmd       = ($urandom_range(0, 99) < 15) ? CMD_SORT : CMD_INSERT;
    item.name_head = {$urandom, $urandom};
    item.name_tail = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50 && key_pool.size() > 0)
      item.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (pick < 62)
      item.key = boundary_keys[$urandom_range(0, 5)];
    else
      item.key = $urandom;
    if (item.cmd == CMD_INSERT) key_pool.push_back(item.key);
    return item;
  endfunction

  initial begin : stimulus
    in_item_t item;
    record_t  exp_rec;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      item.cmd            = directed_rows[i].cmd;
      item.key            = directed_rows[i].key;
      item.name_head      = directed_rows[i].head;
      item.name_tail      = directed_rows[i].tail;
      exp_rec.key         = directed_rows[i].exp_key;
      exp_rec.name_head   = directed_rows[i].exp_head;
      exp_rec.name_tail   = directed_rows[i].exp_tail;
      if (item.cmd == CMD_INSERT) key_pool.push_back(item.key);
      offer_item(item, directed_rows[i].exp_n, exp_rec);
    end

    random_started = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      item = random_item();
      offer_item(item, -1, '0);
    end
    in_valid_i <= 1'b0;

    // let the monitor book the final transfer before looking at the queue
    @(posedge clk_i);
    while (pending_records.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_records.size() > 0) begin
      err_count++;
      $display("%0t ns: %0d expected records never arrived", $time, pending_records.size());
    end
    $display("covered %0d inserts and %0d sorts, %0d records checked, store ends at %0d",
             inserts_seen, sorts_seen, records_checked, stored_count);
    $display("dropped %0d duplicate keys and %0d records on a full store, long hold %0s",
             dup_drops, full_drops, long_hold_done ? "done" : "missed");
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
